### hdl/bit_sequence_autocorrelator_core_assert.svh
// Assertion macros for the bit sequence autocorrelator.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef BIT_SEQUENCE_AUTOCORRELATOR_CORE_ASSERT_SVH
`define BIT_SEQUENCE_AUTOCORRELATOR_CORE_ASSERT_SVH

// same-cycle implication
`define BSAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bsac_pkg.sv
// Package for the bit sequence autocorrelator: field widths, constants and types.
// No dependencies.
package bsac_pkg;

  localparam int SEQ_LEN_DEF = 4096;
  localparam int LAG_W       = 11;
  localparam int MAG_W       = 13;
  localparam int MAG_MAX     = 8191;
  localparam int MODE_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

### hdl/bit_sequence_autocorrelator_core.sv
// Bit sequence autocorrelator, top level.
// Depends on bsac_pkg and bit_sequence_autocorrelator_core_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): each transaction carries in_mode,
//   in_bit_value and in_lag. Mode clear empties the sequence, mode append stores
//   one bit (ignored once SEQ_LEN bits are held), mode query asks for the
//   magnitude of the circular autocorrelation at in_lag; the unused mode is dropped.
//   Output channel (out_valid / out_stall): one transaction per query, carrying
//   out_lag_echo (lag as given) and out_magnitude (saturated at 8191).
// Timing:
//   Clear and append leave in_stall low. A query keeps in_stall high while the
//   lag is reduced modulo SEQ_LEN, the loaded bits are walked and the read
//   pipeline drains (a lag that reduces to zero skips walk and drain), and on
//   until the output register is free and the result is registered. The walk
//   reads one bit pair a cycle. in_stall is high while a query is being worked on.
// Reset:
//   Synchronous, active low; the sequence is emptied and no result is pending.
//   The bit store itself is not cleared; only loaded entries enter a result.
// Back-pressure:
//   A result waits in the output register while out_stall is high; clears and
//   appends are still taken, and a following query runs but holds its result
//   back until the register is free.
`include "bit_sequence_autocorrelator_core_assert.svh"

module bit_sequence_autocorrelator_core #(
  parameter int SEQ_LEN = bsac_pkg::SEQ_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bsac_pkg::MODE_W-1:0] in_mode,
  input  logic                       in_bit_value,
  input  logic [bsac_pkg::LAG_W-1:0] in_lag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bsac_pkg::LAG_W-1:0] out_lag_echo,
  output logic [bsac_pkg::MAG_W-1:0] out_magnitude
);

  localparam int AW = $clog2(SEQ_LEN);
  localparam int CW = $clog2(SEQ_LEN + 1);
  localparam int KW = (CW > bsac_pkg::LAG_W) ? CW : bsac_pkg::LAG_W;
  localparam int SW = CW + 1;

  bsac_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]               count_r, count_nxt;
  logic [KW-1:0]               k_r, k_nxt;
  logic [CW-1:0]               i_r, i_nxt;
  logic [AW-1:0]               j_r, j_nxt;
  logic signed [SW-1:0]        acc_r, acc_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic                        pair_ok_r, pair_ok_nxt;
  logic [bsac_pkg::LAG_W-1:0]  lag_r, lag_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [bsac_pkg::LAG_W-1:0]  out_lag_r, out_lag_nxt;
  logic [bsac_pkg::MAG_W-1:0]  out_mag_r, out_mag_nxt;

  logic                        mem [SEQ_LEN];
  logic                        rd_i_r, rd_j_r;
  logic                        wr_en;
  logic                        in_take;
  bsac_pkg::mode_t             mode;
  logic [SW-1:0]               mag_abs;
  logic [bsac_pkg::MAG_W-1:0]  mag_sat;

  assign mode    = bsac_pkg::mode_t'(in_mode);
  assign in_take = in_valid && !in_stall;
  assign wr_en   = in_take && (mode == bsac_pkg::MODE_APPEND) && (count_r < CW'(SEQ_LEN));

  assign mag_abs = acc_r[SW-1] ? SW'(-acc_r) : SW'(acc_r);
  assign mag_sat = (32'(mag_abs) > 32'(bsac_pkg::MAG_MAX)) ?
                   bsac_pkg::MAG_W'(bsac_pkg::MAG_MAX) : bsac_pkg::MAG_W'(mag_abs);

  // bit store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= in_bit_value;
    end
    rd_i_r <= mem[i_r[AW-1:0]];
    rd_j_r <= mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsac_pkg::S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r       <= k_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    acc_r     <= acc_nxt;
    pair_ok_r <= pair_ok_nxt;
    lag_r     <= lag_nxt;
    out_lag_r <= out_lag_nxt;
    out_mag_r <= out_mag_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    acc_nxt       = acc_r;
    rd_vld_nxt    = 1'b0;
    pair_ok_nxt   = pair_ok_r;
    lag_nxt       = lag_r;
    out_lag_nxt   = out_lag_r;
    out_mag_nxt   = out_mag_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != bsac_pkg::S_IDLE);

    if (rd_vld_r && pair_ok_r) begin
      acc_nxt = (rd_i_r == rd_j_r) ? acc_r + SW'(1) : acc_r - SW'(1);
    end

    unique case (state_r)
      bsac_pkg::S_IDLE: begin
        if (in_take) begin
          case (mode)
            bsac_pkg::MODE_CLEAR: count_nxt = '0;
            bsac_pkg::MODE_APPEND: begin
              if (wr_en) begin
                count_nxt = count_r + CW'(1);
              end
            end
            bsac_pkg::MODE_QUERY: begin
              lag_nxt   = in_lag;
              k_nxt     = KW'(in_lag);
              acc_nxt   = '0;
              state_nxt = bsac_pkg::S_REDUCE;
            end
            default: ;
          endcase
        end
      end
      bsac_pkg::S_REDUCE: begin
        if (k_r >= KW'(SEQ_LEN)) begin
          k_nxt = k_r - KW'(SEQ_LEN);
        end else if (k_r == '0) begin
          state_nxt = bsac_pkg::S_DONE;
        end else begin
          i_nxt     = '0;
          j_nxt     = k_r[AW-1:0];
          state_nxt = bsac_pkg::S_WALK;
        end
      end
      bsac_pkg::S_WALK: begin
        if (i_r < count_r) begin
          rd_vld_nxt  = 1'b1;
          pair_ok_nxt = (CW'(j_r) < count_r);
          i_nxt       = i_r + CW'(1);
          j_nxt       = (j_r == AW'(SEQ_LEN - 1)) ? '0 : j_r + AW'(1);
        end else begin
          state_nxt = bsac_pkg::S_DRAIN;
        end
      end
      bsac_pkg::S_DRAIN: state_nxt = bsac_pkg::S_DONE;
      bsac_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_lag_nxt   = lag_r;
          out_mag_nxt   = mag_sat;
          state_nxt     = bsac_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsac_pkg::S_IDLE;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_lag_echo  = out_lag_r;
  assign out_magnitude = out_mag_r;

  `BSAC_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(SEQ_LEN),
    "loaded count beyond sequence length")
  `BSAC_ASSERT_IMP(a_rd_from_walk, clk, rst_n, rd_vld_r, $past(state_r) == bsac_pkg::S_WALK,
    "read data valid outside the walk")
  `BSAC_ASSERT_IMP(a_walk_range, clk, rst_n, state_r == bsac_pkg::S_WALK,
    (i_r <= count_r) && (k_r < KW'(SEQ_LEN)), "walk index or lag out of range")
  `BSAC_ASSERT_IMP(a_done_drained, clk, rst_n, state_r == bsac_pkg::S_DONE, !rd_vld_r,
    "result taken before the read pipeline drained")

endmodule

### tb/tb_top.sv
// Self-checking testbench for bit_sequence_autocorrelator_core.
// Directed table then random load/query sequences, checked against a local predictor.
// Depends on bsac_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int SEQ_LEN        = bsac_pkg::SEQ_LEN_DEF;
  localparam int RAND_ITEMS     = 70;
  localparam int RAND_QUERIES   = 18;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4 * SEQ_LEN + 1000;
  localparam int DRAIN_CYCLES   = SEQ_LEN + 8;
  localparam int SCRIPT_ROWS    = 25;

  typedef struct packed {
    logic [bsac_pkg::LAG_W-1:0] lag;
    logic [bsac_pkg::MAG_W-1:0] mag;
  } corr_t;

  typedef struct packed {
    bsac_pkg::mode_t            mode;
    logic                       bitv;
    logic [bsac_pkg::LAG_W-1:0] lag;
    logic [12:0]                reps;
    logic                       typed;
    logic [bsac_pkg::MAG_W-1:0] mag;
  } script_row_t;

  localparam script_row_t SCRIPT [0:SCRIPT_ROWS-1] = '{
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd5,    13'd1,  1'b1, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd0,    13'd1,  1'b1, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b1, 11'd2047, 13'd1,  1'b1, 13'd0},
    '{bsac_pkg::MODE_NONE,   1'b1, 11'd2047, 13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_APPEND, 1'b1, 11'd0,    13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd1,    13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_APPEND, 1'b0, 11'd2047, 13'd7,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd3,    13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd0,    13'd1,  1'b1, 13'd0},
    '{bsac_pkg::MODE_NONE,   1'b0, 11'd0,    13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd1,    13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_CLEAR,  1'b1, 11'd2047, 13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd1,    13'd1,  1'b1, 13'd0},
    '{bsac_pkg::MODE_APPEND, 1'b1, 11'd0,    13'd16, 1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd1,    13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_APPEND, 1'b0, 11'd0,    13'd4,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd2047, 13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd1024, 13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_CLEAR,  1'b0, 11'd0,    13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_APPEND, 1'b0, 11'd0,    13'd8,  1'b0, 13'd0},
    '{bsac_pkg::MODE_APPEND, 1'b1, 11'd0,    13'd8,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b1, 11'd1,    13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd2047, 13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_CLEAR,  1'b0, 11'd0,    13'd1,  1'b0, 13'd0},
    '{bsac_pkg::MODE_QUERY,  1'b0, 11'd7,    13'd1,  1'b1, 13'd0}
  };

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [bsac_pkg::MODE_W-1:0] in_mode;
  logic                        in_bit_value;
  logic [bsac_pkg::LAG_W-1:0]  in_lag;
  logic                        out_valid;
  logic                        out_stall;
  logic [bsac_pkg::LAG_W-1:0]  out_lag_echo;
  logic [bsac_pkg::MAG_W-1:0]  out_magnitude;

  logic  seq_bits [SEQ_LEN];
  int    seq_count;
  corr_t corr_q [$];
  int    fed_items;
  int    fed_queries;
  int    errors = 0;
  int    stuck_cycles;
  bit    hold_long;
  bit    quiet;

  bit_sequence_autocorrelator_core #(
    .SEQ_LEN(SEQ_LEN)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_bit_value (in_bit_value),
    .in_lag       (in_lag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_lag_echo (out_lag_echo),
    .out_magnitude(out_magnitude)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [bsac_pkg::MAG_W-1:0] circ_corr(
      logic [bsac_pkg::LAG_W-1:0] lag);
    int k;
    int i;
    int j;
    int acc;
    k = int'(lag) % SEQ_LEN;
    acc = 0;
    if (k == 0) return '0;
    for (i = 0; i < seq_count; i++) begin
      j = i + k;
      if (j >= SEQ_LEN) j -= SEQ_LEN;
      if (j < seq_count) acc += (seq_bits[i] == seq_bits[j]) ? 1 : -1;
    end
    if (acc < 0) acc = -acc;
    if (acc > bsac_pkg::MAG_MAX) acc = bsac_pkg::MAG_MAX;
    return acc[bsac_pkg::MAG_W-1:0];
  endfunction

  function automatic void apply_transaction(bsac_pkg::mode_t m, logic b,
                                            logic [bsac_pkg::LAG_W-1:0] l, logic typed,
                                            logic [bsac_pkg::MAG_W-1:0] mag);
    corr_t want;
    case (m)
      bsac_pkg::MODE_CLEAR: seq_count = 0;
      bsac_pkg::MODE_APPEND: begin
        if (seq_count < SEQ_LEN) begin
          seq_bits[seq_count] = b;
          seq_count++;
        end
      end
      bsac_pkg::MODE_QUERY: begin
        want.lag = l;
        want.mag = typed ? mag : circ_corr(l);
        corr_q.push_back(want);
        fed_queries++;
      end
      default: ;
    endcase
    if (m != bsac_pkg::MODE_NONE) fed_items++;
  endfunction

  task automatic put_transaction(bsac_pkg::mode_t m, logic b,
                                 logic [bsac_pkg::LAG_W-1:0] l, logic typed,
                                 logic [bsac_pkg::MAG_W-1:0] mag);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_mode      <= m;
    in_bit_value <= b;
    in_lag       <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_transaction(m, b, l, typed, mag);
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_idle(bit calm);
    if (!calm && $urandom_range(0, 4) == 0) idle_input($urandom_range(1, 17));
  endtask

  function automatic logic [bsac_pkg::LAG_W-1:0] pick_lag();
    int pick;
    int hi;
    pick = $urandom_range(0, 3);
    hi = (seq_count + 1 > 2047) ? 2047 : seq_count + 1;
    case (pick)
      0: return bsac_pkg::LAG_W'($urandom_range(0, 2047));
      1: return bsac_pkg::LAG_W'($urandom_range(0, hi));
      2: return bsac_pkg::LAG_W'($urandom_range(0, 7));
      default: return bsac_pkg::LAG_W'(2047 - $urandom_range(0, 7));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    corr_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (corr_q.size() == 0) begin
        $error("unexpected transaction: lag_echo %0d magnitude %0d",
               out_lag_echo, out_magnitude);
        errors++;
      end else begin
        want = corr_q.pop_front();
        if (out_lag_echo !== want.lag) begin
          $error("lag_echo: expected %0d, actual %0d", want.lag, out_lag_echo);
          errors++;
        end
        if (out_magnitude !== want.mag) begin
          $error("magnitude: expected %0d, actual %0d", want.mag, out_magnitude);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : result_sink
    bit long_done;
    long_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long && !long_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        long_done = 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clk);
            out_stall <= 1'b0;
          end
          2: begin
            out_stall <= 1'b0;
            repeat ($urandom_range(20, 60)) @(negedge clk);
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin : stimulus
    int r;
    int n;
    int k;
    int n_bits;
    int n_q;
    int seq_idx;
    int item_base;
    int query_base;
    bit calm_seq;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = bsac_pkg::MODE_CLEAR;
    in_bit_value = 1'b0;
    in_lag       = '0;
    seq_count    = 0;
    fed_items    = 0;
    fed_queries  = 0;
    hold_long    = 1'b0;
    quiet        = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < SCRIPT_ROWS; r++) begin
      for (n = 0; n < int'(SCRIPT[r].reps); n++) begin
        if ($urandom_range(0, 31) == 0) idle_input($urandom_range(1, 17));
        put_transaction(SCRIPT[r].mode, SCRIPT[r].bitv, SCRIPT[r].lag,
                        SCRIPT[r].typed, SCRIPT[r].mag);
      end
    end

    item_base  = fed_items;
    query_base = fed_queries;
    seq_idx    = 0;
    while (fed_items - item_base < RAND_ITEMS || fed_queries - query_base < RAND_QUERIES ||
           seq_idx < 8) begin
      quiet = (fed_items - item_base >= RAND_ITEMS - 30) &&
              (fed_queries - query_base >= RAND_QUERIES - 8);
      calm_seq = quiet || ($urandom_range(0, 2) == 0);
      if (seq_idx == 7) begin
        idle_input(1);
        while (corr_q.size() != 0) @(posedge clk);
      end
      if (seq_idx != 3 && $urandom_range(0, 9) == 0) begin
        maybe_idle(calm_seq);
        put_transaction(bsac_pkg::mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        bsac_pkg::LAG_W'($urandom_range(0, 2047)), 1'b0, '0);
      end else begin
        if (seq_idx == 3 || $urandom_range(0, 3) != 0) begin
          maybe_idle(calm_seq);
          put_transaction(bsac_pkg::MODE_CLEAR, 1'($urandom_range(0, 1)),
                          bsac_pkg::LAG_W'($urandom_range(0, 2047)), 1'b0, '0);
        end
        n_bits = (seq_idx != 3 && $urandom_range(0, 15) == 0) ? $urandom_range(30, 60)
                                                               : $urandom_range(0, 12);
        for (k = 0; k < n_bits; k++) begin
          maybe_idle(calm_seq);
          put_transaction(bsac_pkg::MODE_APPEND, 1'($urandom_range(0, 1)),
                          bsac_pkg::LAG_W'($urandom_range(0, 2047)), 1'b0, '0);
        end
        n_q = (seq_idx == 3) ? 4 : $urandom_range(1, 4);
        if (seq_idx == 3) hold_long = 1'b1;
        for (k = 0; k < n_q; k++) begin
          maybe_idle(calm_seq);
          put_transaction(bsac_pkg::MODE_QUERY, 1'($urandom_range(0, 1)), pick_lag(),
                          1'b0, '0);
        end
      end
      seq_idx++;
    end

    idle_input(1);
    while (corr_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/bsac_pkg.sv
hdl/bit_sequence_autocorrelator_core.sv
tb/tb_top.sv
